// ----- rtl/core/signed_int_to_decimal_ascii_unit_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the decimal text unit
// Concurrent checks, sampled on clk and disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_UNIT_MACROS_SVH

// same-cycle implication
`define S2D_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define S2D_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/s2d_pkg.sv -----
// ---------------------------------------------------------------------------
// s2d_pkg
// Shared widths, characters and controller/datapath interface types.
// ---------------------------------------------------------------------------
package s2d_pkg;

  localparam int DATA_W     = 64;
  localparam int NUM_DIGITS = 20;
  localparam int BCD_W      = 4 * NUM_DIGITS;
  localparam int CHAR_W     = 8;
  localparam int BIT_CNT_W  = 6;
  localparam int DIG_CNT_W  = 5;

  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2d;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic skip_step;
    logic emit_sign;
    logic emit_digit;
    logic last;
  } s2d_cmd_t;

  typedef struct packed {
    logic top_zero;
    logic neg;
  } s2d_status_t;

endpackage

// ----- rtl/core/s2d_dp.sv -----
// ---------------------------------------------------------------------------
// s2d_dp
// Datapath: magnitude, double-dabble BCD register and output character.
// ---------------------------------------------------------------------------
module s2d_dp (
  input  logic                         clk,
  input  logic [s2d_pkg::DATA_W-1:0]   in_value,
  input  s2d_pkg::s2d_cmd_t            cmd,
  output s2d_pkg::s2d_status_t         status,
  output logic [s2d_pkg::CHAR_W-1:0]   out_char,
  output logic                         out_last
);

  logic [s2d_pkg::DATA_W-1:0] bin_r, bin_nxt;
  logic [s2d_pkg::BCD_W-1:0]  bcd_r, bcd_nxt, bcd_adj;
  logic                       neg_r, neg_nxt;
  logic [s2d_pkg::CHAR_W-1:0] char_r, char_nxt;
  logic                       last_r, last_nxt;
  logic [3:0]                 top_digit;

  assign top_digit = bcd_r[s2d_pkg::BCD_W-1 -: 4];

  // add 3 to every digit of 5 or more before the shift
  always_comb begin
    logic [3:0] d;
    for (int i = 0; i < s2d_pkg::NUM_DIGITS; i++) begin
      d = bcd_r[4*i +: 4];
      bcd_adj[4*i +: 4] = (d >= 4'd5) ? d + 4'd3 : d;
    end
  end

  always_comb begin
    bin_nxt  = bin_r;
    bcd_nxt  = bcd_r;
    neg_nxt  = neg_r;
    char_nxt = char_r;
    last_nxt = last_r;
    if (cmd.load) begin
      neg_nxt = in_value[s2d_pkg::DATA_W-1];
      bin_nxt = in_value[s2d_pkg::DATA_W-1] ? (~in_value + 1'b1) : in_value;
      bcd_nxt = '0;
    end else if (cmd.conv_step) begin
      bcd_nxt = {bcd_adj[s2d_pkg::BCD_W-2:0], bin_r[s2d_pkg::DATA_W-1]};
      bin_nxt = {bin_r[s2d_pkg::DATA_W-2:0], 1'b0};
    end else if (cmd.skip_step) begin
      bcd_nxt = {bcd_r[s2d_pkg::BCD_W-5:0], 4'b0};
    end else if (cmd.emit_sign) begin
      char_nxt = s2d_pkg::CHAR_MINUS;
      last_nxt = 1'b0;
    end else if (cmd.emit_digit) begin
      char_nxt = s2d_pkg::CHAR_ZERO + {4'b0, top_digit};
      last_nxt = cmd.last;
      bcd_nxt  = {bcd_r[s2d_pkg::BCD_W-5:0], 4'b0};
    end
  end

  always_ff @(posedge clk) begin
    bin_r  <= bin_nxt;
    bcd_r  <= bcd_nxt;
    neg_r  <= neg_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  assign status.top_zero = (top_digit == 4'd0);
  assign status.neg      = neg_r;
  assign out_char        = char_r;
  assign out_last        = last_r;

endmodule

// ----- rtl/core/s2d_ctrl.sv -----
// ---------------------------------------------------------------------------
// s2d_ctrl
// Controller: sequences load, 64 shift steps, zero skip, sign and digits.
// ---------------------------------------------------------------------------
`include "signed_int_to_decimal_ascii_unit_macros.svh"

module s2d_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  input  s2d_pkg::s2d_status_t  status,
  output s2d_pkg::s2d_cmd_t     cmd
);

  typedef enum logic [2:0] {S_IDLE, S_CONV, S_SKIP, S_SIGN, S_EMIT} state_t;

  state_t                          state_r, state_nxt;
  logic [s2d_pkg::BIT_CNT_W-1:0]   bit_cnt_r, bit_cnt_nxt;
  logic [s2d_pkg::DIG_CNT_W-1:0]   dig_cnt_r, dig_cnt_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic                            slot_free;

  localparam logic [s2d_pkg::BIT_CNT_W-1:0] BIT_LAST =
    s2d_pkg::BIT_CNT_W'(s2d_pkg::DATA_W - 1);
  localparam logic [s2d_pkg::DIG_CNT_W-1:0] DIG_FULL =
    s2d_pkg::DIG_CNT_W'(s2d_pkg::NUM_DIGITS);
  localparam logic [s2d_pkg::DIG_CNT_W-1:0] DIG_ONE =
    s2d_pkg::DIG_CNT_W'(1);

  assign slot_free = !out_valid_r || out_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  always_comb begin
    state_nxt   = state_r;
    bit_cnt_nxt = bit_cnt_r;
    dig_cnt_nxt = dig_cnt_r;
    cmd         = '0;
    out_valid_nxt = out_valid_r && !out_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load    = 1'b1;
          bit_cnt_nxt = '0;
          state_nxt   = S_CONV;
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        bit_cnt_nxt   = bit_cnt_r + 1'b1;
        if (bit_cnt_r == BIT_LAST) begin
          dig_cnt_nxt = DIG_FULL;
          state_nxt   = S_SKIP;
        end
      end
      S_SKIP: begin
        // drop leading zero digits, keep at least one
        if (status.top_zero && dig_cnt_r != DIG_ONE) begin
          cmd.skip_step = 1'b1;
          dig_cnt_nxt   = dig_cnt_r - 1'b1;
        end else begin
          state_nxt = status.neg ? S_SIGN : S_EMIT;
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          cmd.emit_sign = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_EMIT;
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          cmd.emit_digit = 1'b1;
          cmd.last       = (dig_cnt_r == DIG_ONE);
          out_valid_nxt  = 1'b1;
          dig_cnt_nxt    = dig_cnt_r - 1'b1;
          if (dig_cnt_r == DIG_ONE) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      bit_cnt_r   <= '0;
      dig_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bit_cnt_r   <= bit_cnt_nxt;
      dig_cnt_r   <= dig_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `S2D_ASSERT_NOW(a_emit_into_free_slot, cmd.emit_sign || cmd.emit_digit, !out_valid_r || out_tready, "emit over a word not yet taken")
  `S2D_ASSERT_NEXT(a_conv_to_skip, state_r == S_CONV && bit_cnt_r == BIT_LAST, state_r == S_SKIP, "conversion did not end after the last bit")
  `S2D_ASSERT_NOW(a_digits_left, state_r == S_SKIP || state_r == S_SIGN || state_r == S_EMIT, dig_cnt_r != '0, "digit count ran out while emitting")
  `S2D_ASSERT_NEXT(a_accept_starts_conv, in_tvalid && in_tready, state_r == S_CONV && bit_cnt_r == '0, "accepted word did not start conversion")

endmodule

// ----- rtl/core/signed_int_to_decimal_ascii_unit.sv -----
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit
// Signed 64-bit integer to decimal ASCII text, one character per word.
// ---------------------------------------------------------------------------
// channel | dir | tdata                  | tuser | tlast
// in_     | in  | [63:0] value (signed)  | -     | -
// out_    | out | [7:0] character        | -     | last character of the text
//
// One input word passes through an accept, the double-dabble shift steps,
// a loop that drops the leading zero digits of the magnitude (keeping at
// least one), the sign of a negative value, then one character per digit.
// The block takes no new word until the last character of the previous one
// has been issued into the output register.
// The 64-step shift loop of the BCD register takes the bulk of the time.
// rst_n is synchronous; it clears the controller and the output valid.
// Output stalls hold the current character and pause the sequencer.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  input  logic [s2d_pkg::DATA_W-1:0]   in_tdata,   // [63:0] value
  output logic                         out_tvalid,
  input  logic                         out_tready,
  output logic [s2d_pkg::CHAR_W-1:0]   out_tdata,  // [7:0] character
  output logic                         out_tlast
);

  s2d_pkg::s2d_cmd_t    cmd;
  s2d_pkg::s2d_status_t status;

  s2d_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .status     (status),
    .cmd        (cmd)
  );

  s2d_dp u_dp (
    .clk      (clk),
    .in_value (in_tdata),
    .cmd      (cmd),
    .status   (status),
    .out_char (out_tdata),
    .out_last (out_tlast)
  );

endmodule

// ----- tb/sv/signed_int_to_decimal_ascii_unit_tb.sv -----
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// signed_int_to_decimal_ascii_unit_tb
// Drives signed 64-bit words into the decimal text unit and checks every
// character word against the directed text column or, where that is empty,
// a built-in decimal conversion. A directed table covers zero, the
// extremes and digit-count edges. A random part follows. Input idle gaps
// and output stalls, both random, run throughout, with no-idle stretches.
// ---------------------------------------------------------------------------
module signed_int_to_decimal_ascii_unit_tb;

  localparam int DIRECTED_ROWS = 18;
  localparam int RANDOM_ITEMS  = 82;
  localparam int DRAIN_CYCLES  = 150;
  localparam int CYCLE_LIMIT   = 1000000;

  typedef struct packed {
    logic [s2d_pkg::CHAR_W-1:0] code;
    logic                       last;
  } char_word_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_tvalid;
  logic                       in_tready;
  logic [s2d_pkg::DATA_W-1:0] in_tdata;    // [63:0] value
  logic                       out_tvalid;
  logic                       out_tready;
  logic [s2d_pkg::CHAR_W-1:0] out_tdata;   // [7:0] character
  logic                       out_tlast;

  char_word_t char_words_due[$];
  int         mismatch_count = 0;
  int         texts_done = 0;
  int         cycle_count = 0;
  bit         no_idle;

  // value column; text column holds the expected text where it is obvious
  logic [s2d_pkg::DATA_W-1:0] dir_value [DIRECTED_ROWS] = '{
    64'd0,
    64'd1,
    -64'd1,
    64'd9,
    64'd10,
    -64'd10,
    64'd99,
    64'd100,
    64'h7FFF_FFFF_FFFF_FFFF,
    64'h8000_0000_0000_0000,
    64'h8000_0000_0000_0001,
    64'd999_999_999_999_999_999,
    64'd1_000_000_000_000_000_000,
    -64'd1_000_000_000_000_000_000,
    64'h5555_5555_5555_5555,
    64'hAAAA_AAAA_AAAA_AAAA,
    64'd1234567890,
    -64'd9
  };
  string dir_text [DIRECTED_ROWS] = '{
    "0",
    "1",
    "-1",
    "9",
    "10",
    "-10",
    "99",
    "100",
    "9223372036854775807",
    "-9223372036854775808",
    "-9223372036854775807",
    "",
    "",
    "",
    "",
    "",
    "",
    ""
  };

  signed_int_to_decimal_ascii_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH @%0d: %s", cycle_count, msg);
    mismatch_count++;
  endtask

  // mostly short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(10, 60);
  endfunction

  // decimal text of a signed value, magnitude taken unsigned so the most
  // negative value works
  function automatic void push_decimal_text(input logic [s2d_pkg::DATA_W-1:0] value);
    logic [s2d_pkg::DATA_W-1:0] mag;
    logic [3:0]                 digit [s2d_pkg::NUM_DIGITS];
    int                         nd;
    logic                       neg;
    neg = value[s2d_pkg::DATA_W-1];
    mag = neg ? (~value + 64'd1) : value;
    nd  = 0;
    do begin
      digit[nd] = 4'(mag % 64'd10);
      mag       = mag / 64'd10;
      nd++;
    end while (mag != 0 && nd < s2d_pkg::NUM_DIGITS);
    if (neg) char_words_due.push_back('{code: s2d_pkg::CHAR_MINUS, last: 1'b0});
    for (int i = nd - 1; i >= 0; i--)
      char_words_due.push_back('{code: s2d_pkg::CHAR_ZERO + s2d_pkg::CHAR_W'(digit[i]),
                                 last: (i == 0)});
  endfunction

  function automatic void push_text(input string text);
    for (int i = 0; i < text.len(); i++)
      char_words_due.push_back('{code: text.getc(i), last: (i == text.len() - 1)});
  endfunction

  function automatic logic [s2d_pkg::DATA_W-1:0] pick_value();
    logic [s2d_pkg::DATA_W-1:0] v;
    logic [s2d_pkg::DATA_W-1:0] p10;
    int                         k;
    v = {$urandom, $urandom};
    case ($urandom_range(0, 9))
      3, 4: v = s2d_pkg::DATA_W'($urandom_range(0, 999));
      5, 6: v = {32'd0, $urandom} >> $urandom_range(0, 31);
      7: begin
        // around a power of ten, where the digit count changes
        k   = $urandom_range(1, 18);
        p10 = 64'd1;
        for (int i = 0; i < k; i++) p10 = p10 * 64'd10;
        v = p10 + s2d_pkg::DATA_W'($urandom_range(0, 2)) - 64'd1;
      end
      8: v = $urandom_range(0, 1)
             ? 64'h7FFF_FFFF_FFFF_FFFF - s2d_pkg::DATA_W'($urandom_range(0, 3))
             : 64'h8000_0000_0000_0000 + s2d_pkg::DATA_W'($urandom_range(0, 3));
      default: ;
    endcase
    if (!v[s2d_pkg::DATA_W-1] && $urandom_range(0, 1)) v = ~v + 64'd1;
    return v;
  endfunction

  // called at a falling edge; returns at the falling edge after the accept
  task automatic send_value(input logic [s2d_pkg::DATA_W-1:0] value, input string text);
    int gap;
    gap = no_idle ? 0 : idle_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {$urandom, $urandom};
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= value;
    do @(posedge clk); while (!in_tready);
    if (text.len() > 0) push_text(text);
    else push_decimal_text(value);
    @(negedge clk);
  endtask

  // output stalls: one assignment per falling edge
  initial begin : out_ready_gen
    int  hold;
    bit  level;
    hold       = 0;
    level      = 1'b0;
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (no_idle) begin
        level = 1'b1;
        hold  = 0;
      end else if (hold == 0) begin
        level = ($urandom_range(0, 99) < 65);
        hold  = level ? $urandom_range(1, 8) : (idle_len() + 1);
      end
      if (hold > 0) hold--;
      out_tready <= level;
    end
  end

  always @(posedge clk) begin : char_monitor
    char_word_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (char_words_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h last %b", out_tdata, out_tlast));
      end else begin
        due = char_words_due.pop_front();
        if (out_tdata !== due.code)
          report_mismatch($sformatf("text %0d: character %h, expected %h",
                                    texts_done, out_tdata, due.code));
        if (out_tlast !== due.last)
          report_mismatch($sformatf("text %0d: last %b, expected %b",
                                    texts_done, out_tlast, due.last));
        if (due.last) texts_done++;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", char_words_due.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    no_idle        = 1'b0;
    rst_n          = 1'b0;
    in_tvalid      = 1'b0;
    in_tdata       = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIRECTED_ROWS; i++) send_value(dir_value[i], dir_text[i]);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      // every third stretch of 20 words runs with no idling at all
      no_idle = ((i / 20) % 3 == 0);
      send_value(pick_value(), "");
    end
    no_idle = 1'b0;
    in_tvalid <= 1'b0;

    while (char_words_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
